[rtl/core/srd_pkg.sv]
`timescale 1ns / 1ps

package srd_pkg;

    // Field widths of the result channel.
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned INDEX_W  = 6;

    // Frame delimiters and checksum seed.
    localparam logic [7:0] BYTE_DELIM  = 8'h07;
    localparam logic [7:0] BYTE_START2 = 8'hF0;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] BYTE_END2   = 8'h0F;
    localparam logic [7:0] SUM_SEED    = 8'hAD;

    // Register map.
    localparam logic [1:0] REG_REPLY_COMMAND = 2'd0;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DATA      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_START = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CMD   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_SUM   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_END   = 3'd5;

    // Position within the frame.
    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_START2 = 4'd1,
        PH_ZERO   = 4'd2,
        PH_CMD    = 4'd3,
        PH_LEN    = 4'd4,
        PH_DATA   = 4'd5,
        PH_CSUM   = 4'd6,
        PH_END1   = 4'd7,
        PH_END2   = 4'd8
    } t_phase;

    // Sequencer of the shared compare and add unit.
    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_EVAL = 2'd1,
        SQ_READ = 2'd2,
        SQ_EMIT = 2'd3
    } t_seq;

endpackage

[rtl/core/srd_in_if.sv]
`timescale 1ns / 1ps

interface srd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/core/srd_out_if.sv]
`timescale 1ns / 1ps

interface srd_out_if;
    logic                           valid;
    logic                           ready;
    logic [srd_pkg::STATUS_W-1:0]   status;
    logic [7:0]                     payload_byte;
    logic [srd_pkg::INDEX_W-1:0]    payload_index;
    logic                           last;

    modport source (
        output valid, output status, output payload_byte,
        output payload_index, output last, input ready
    );
    modport sink (
        input valid, input status, input payload_byte,
        input payload_index, input last, output ready
    );
endinterface

[rtl/core/srd_ram.sv]
`timescale 1ns / 1ps

module srd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/serial_response_deframer.sv]
`timescale 1ns / 1ps

// Reply frame receiver. Bytes from the serial line arrive on i_rx, one per
// transfer; results leave on o_rsp. A frame is 07 F0 00 <cmd> <len> <data>
// <sum> 07 0F, where <cmd> must equal the reply_command register (APB byte
// address 0) and the sum starts at 0xAD over 00, cmd, len and data, counting
// only the first 0x07. Data bytes are held in a small RAM and, once the end
// pair checks out, sent as one result each with last on the final one. Any
// mismatch gives a single error result with last set.
// Each byte takes the transfer and then one pass through the shared compare
// and add unit; i_rx is not ready during that pass, so a new byte is taken
// only once the last is through. A good frame drains one data byte at a time
// through the single registered RAM read port; i_rx stays low till it ends.
// A stall on o_rsp holds the result in the output register; a new byte is
// still taken, but its own result waits until the register is free.
// Reset empties the output register, clears reply_command and puts the
// receiver back to hunting for a start byte; no clearing pass is needed.
module serial_response_deframer #(
    parameter int unsigned MAX_PAYLOAD = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    srd_in_if.sink               i_rx,
    srd_out_if.source            o_rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned CW = srd_pkg::INDEX_W;

    srd_pkg::t_seq   r_seq, n_seq;
    srd_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_sum, n_sum;
    logic            r_seen, n_seen;
    logic [CW-1:0]   r_len, n_len;
    logic [CW-1:0]   r_taken, n_taken;
    logic [CW-1:0]   r_idx, n_idx;
    logic [7:0]      r_byte;
    logic [7:0]      r_cmd;

    logic                          r_out_valid, n_out_valid;
    logic [srd_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic [7:0]                    r_out_byte, n_out_byte;
    logic [CW-1:0]                 r_out_index, n_out_index;
    logic                          r_out_last, n_out_last;

    logic                          out_free;
    logic [7:0]                    expected;
    logic                          match;
    logic                          add_en;
    logic [7:0]                    sum_added;
    logic                          sum_skip;
    logic                          ram_we;
    logic [7:0]                    ram_rdata;
    logic                          rx_accept;
    logic [srd_pkg::STATUS_W-1:0]  err_status;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr == srd_pkg::REG_REPLY_COMMAND) ? {24'd0, r_cmd} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= 8'd0;
        end else if (psel && penable && pwrite && paddr == srd_pkg::REG_REPLY_COMMAND) begin
            r_cmd <= pwdata[7:0];
        end
    end

    assign i_rx.ready = (r_seq == srd_pkg::SQ_IDLE);
    assign rx_accept  = i_rx.valid && i_rx.ready;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.payload_byte  = r_out_byte;
    assign o_rsp.payload_index = r_out_index;
    assign o_rsp.last          = r_out_last;

    assign out_free = !r_out_valid || o_rsp.ready;

    // Shared compare unit: the expected byte depends on the frame position.
    always_comb begin
        case (r_phase)
            srd_pkg::PH_START2: expected = srd_pkg::BYTE_START2;
            srd_pkg::PH_ZERO:   expected = srd_pkg::BYTE_ZERO;
            srd_pkg::PH_CMD:    expected = r_cmd;
            srd_pkg::PH_CSUM:   expected = r_sum;
            srd_pkg::PH_END2:   expected = srd_pkg::BYTE_END2;
            default:            expected = srd_pkg::BYTE_DELIM;
        endcase
    end

    assign match = (r_byte == expected);

    // Shared adder: only the first delimiter byte of a frame enters the sum.
    assign sum_skip  = (r_byte == srd_pkg::BYTE_DELIM) && r_seen;
    assign sum_added = r_sum + r_byte;

    srd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_taken[AW-1:0]),
        .i_wdata (r_byte),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_seq        = r_seq;
        n_phase      = r_phase;
        n_sum        = r_sum;
        n_seen       = r_seen;
        n_len        = r_len;
        n_taken      = r_taken;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_byte   = r_out_byte;
        n_out_index  = r_out_index;
        n_out_last   = r_out_last;
        add_en       = 1'b0;
        ram_we       = 1'b0;
        err_status   = srd_pkg::ST_DATA;

        case (r_seq)
            srd_pkg::SQ_IDLE: begin
                if (rx_accept) begin
                    n_seq = srd_pkg::SQ_EVAL;
                end
            end
            srd_pkg::SQ_EVAL: begin
                n_seq = srd_pkg::SQ_IDLE;
                case (r_phase)
                    srd_pkg::PH_START2: begin
                        if (match) begin
                            n_sum   = srd_pkg::SUM_SEED;
                            n_seen  = 1'b0;
                            n_len   = '0;
                            n_taken = '0;
                            n_phase = srd_pkg::PH_ZERO;
                        end else begin
                            err_status = srd_pkg::ST_BAD_START;
                        end
                    end
                    srd_pkg::PH_ZERO: begin
                        if (match) begin
                            add_en  = 1'b1;
                            n_phase = srd_pkg::PH_CMD;
                        end else begin
                            err_status = srd_pkg::ST_BAD_CMD;
                        end
                    end
                    srd_pkg::PH_CMD: begin
                        if (match) begin
                            add_en  = 1'b1;
                            n_phase = srd_pkg::PH_LEN;
                        end else begin
                            err_status = srd_pkg::ST_BAD_CMD;
                        end
                    end
                    srd_pkg::PH_LEN: begin
                        if (r_byte <= 8'(MAX_PAYLOAD)) begin
                            add_en  = 1'b1;
                            n_len   = r_byte[CW-1:0];
                            n_taken = '0;
                            n_phase = (r_byte == 8'd0) ? srd_pkg::PH_CSUM
                                                       : srd_pkg::PH_DATA;
                        end else begin
                            err_status = srd_pkg::ST_TOO_LONG;
                        end
                    end
                    srd_pkg::PH_DATA: begin
                        add_en  = 1'b1;
                        ram_we  = (r_taken < CW'(MAX_PAYLOAD));
                        n_taken = r_taken + 1'b1;
                        if (n_taken >= r_len) begin
                            n_phase = srd_pkg::PH_CSUM;
                        end
                    end
                    srd_pkg::PH_CSUM: begin
                        if (match) begin
                            n_phase = srd_pkg::PH_END1;
                        end else begin
                            err_status = srd_pkg::ST_BAD_SUM;
                        end
                    end
                    srd_pkg::PH_END1: begin
                        if (match) begin
                            n_phase = srd_pkg::PH_END2;
                        end else begin
                            err_status = srd_pkg::ST_BAD_END;
                        end
                    end
                    srd_pkg::PH_END2: begin
                        if (match) begin
                            n_phase = srd_pkg::PH_HUNT;
                            n_idx   = '0;
                            if (r_len != '0) begin
                                n_seq = srd_pkg::SQ_READ;
                            end
                        end else begin
                            err_status = srd_pkg::ST_BAD_END;
                        end
                    end
                    default: begin
                        n_phase = match ? srd_pkg::PH_START2 : srd_pkg::PH_HUNT;
                    end
                endcase

                // A failed check in any position but hunting and data gives
                // an error result; it waits here until the output is free.
                if (!match && r_phase != srd_pkg::PH_HUNT && r_phase != srd_pkg::PH_DATA
                        && r_phase != srd_pkg::PH_LEN) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = err_status;
                        n_out_byte   = 8'd0;
                        n_out_index  = '0;
                        n_out_last   = 1'b1;
                        n_phase      = (r_byte == srd_pkg::BYTE_DELIM) ? srd_pkg::PH_START2
                                                                       : srd_pkg::PH_HUNT;
                    end else begin
                        n_seq   = srd_pkg::SQ_EVAL;
                        n_phase = r_phase;
                    end
                end else if (r_phase == srd_pkg::PH_LEN && r_byte > 8'(MAX_PAYLOAD)) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = err_status;
                        n_out_byte   = 8'd0;
                        n_out_index  = '0;
                        n_out_last   = 1'b1;
                        n_phase      = srd_pkg::PH_HUNT;
                    end else begin
                        n_seq = srd_pkg::SQ_EVAL;
                    end
                end

                if (add_en && !sum_skip) begin
                    n_sum = sum_added;
                    if (r_byte == srd_pkg::BYTE_DELIM) begin
                        n_seen = 1'b1;
                    end
                end
            end
            srd_pkg::SQ_READ: begin
                n_seq = srd_pkg::SQ_EMIT;
            end
            srd_pkg::SQ_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = srd_pkg::ST_DATA;
                    n_out_byte   = ram_rdata;
                    n_out_index  = r_idx;
                    n_out_last   = (r_idx + 1'b1 == r_len);
                    if (r_idx + 1'b1 == r_len) begin
                        n_seq = srd_pkg::SQ_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_seq = srd_pkg::SQ_READ;
                    end
                end
            end
            default: begin
                n_seq = srd_pkg::SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= srd_pkg::SQ_IDLE;
            r_phase     <= srd_pkg::PH_HUNT;
            r_sum       <= srd_pkg::SUM_SEED;
            r_seen      <= 1'b0;
            r_len       <= '0;
            r_taken     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_sum       <= n_sum;
            r_seen      <= n_seen;
            r_len       <= n_len;
            r_taken     <= n_taken;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_accept) begin
            r_byte <= i_rx.rx_byte;
        end
        r_out_status <= n_out_status;
        r_out_byte   <= n_out_byte;
        r_out_index  <= n_out_index;
        r_out_last   <= n_out_last;
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned MAX_PAYLOAD     = 32;
    localparam int unsigned IDLE_LIMIT      = 4000;
    localparam int unsigned DRAIN_WAIT      = 40;
    localparam int unsigned ITEMS_PER_PHASE = 72;
    localparam int unsigned N_SETTINGS      = 6;

    typedef struct {
        logic [srd_pkg::STATUS_W-1:0] status;
        logic [7:0]                   payload;
        logic [srd_pkg::INDEX_W-1:0]  index;
        logic                         last;
    } t_reply;

    // Tracks the frame position of the receiver and holds the replies that
    // each accepted byte is due to produce, oldest first.
    class frame_scoreboard;
        t_reply          expected_q[$];
        srd_pkg::t_phase phase;
        logic [7:0]      sum;
        logic [7:0]      frame_len;
        logic [7:0]      taken;
        logic [7:0]      command;
        bit              seen_delim;
        logic [7:0]      store [MAX_PAYLOAD];
        int unsigned     mismatches;
        int unsigned     data_seen;
        int unsigned     frames_good;
        int unsigned     errors_seen [6];

        function new();
            phase       = srd_pkg::PH_HUNT;
            sum         = srd_pkg::SUM_SEED;
            seen_delim  = 1'b0;
            frame_len   = 8'd0;
            taken       = 8'd0;
            command     = 8'd0;
            mismatches  = 0;
            data_seen   = 0;
            frames_good = 0;
            foreach (errors_seen[i]) errors_seen[i] = 0;
        endfunction

        function void set_command(logic [31:0] value);
            command = value[7:0];
        endfunction

        // Only the first delimiter byte of a frame enters the checksum.
        function void add_sum(logic [7:0] b);
            if (b == srd_pkg::BYTE_DELIM) begin
                if (seen_delim) return;
                seen_delim = 1'b1;
            end
            sum = sum + b;
        endfunction

        // A rejected delimiter byte is taken as the opening of a new frame.
        function void reject(logic [srd_pkg::STATUS_W-1:0] code, logic [7:0] b);
            t_reply r;
            r.status  = code;
            r.payload = 8'd0;
            r.index   = '0;
            r.last    = 1'b1;
            expected_q.push_back(r);
            phase = (b == srd_pkg::BYTE_DELIM) ? srd_pkg::PH_START2 : srd_pkg::PH_HUNT;
        endfunction

        function void note_byte(logic [7:0] b);
            t_reply r;
            int     i;
            case (phase)
                srd_pkg::PH_START2: begin
                    if (b != srd_pkg::BYTE_START2) begin
                        reject(srd_pkg::ST_BAD_START, b);
                    end else begin
                        sum        = srd_pkg::SUM_SEED;
                        seen_delim = 1'b0;
                        frame_len  = 8'd0;
                        taken      = 8'd0;
                        phase      = srd_pkg::PH_ZERO;
                    end
                end
                srd_pkg::PH_ZERO: begin
                    if (b != srd_pkg::BYTE_ZERO) begin
                        reject(srd_pkg::ST_BAD_CMD, b);
                    end else begin
                        add_sum(b);
                        phase = srd_pkg::PH_CMD;
                    end
                end
                srd_pkg::PH_CMD: begin
                    if (b != command) begin
                        reject(srd_pkg::ST_BAD_CMD, b);
                    end else begin
                        add_sum(b);
                        phase = srd_pkg::PH_LEN;
                    end
                end
                srd_pkg::PH_LEN: begin
                    if (b > MAX_PAYLOAD) begin
                        reject(srd_pkg::ST_TOO_LONG, b);
                    end else begin
                        add_sum(b);
                        frame_len = b;
                        taken     = 8'd0;
                        phase     = (b == 8'd0) ? srd_pkg::PH_CSUM : srd_pkg::PH_DATA;
                    end
                end
                srd_pkg::PH_DATA: begin
                    if (taken < MAX_PAYLOAD) store[taken] = b;
                    add_sum(b);
                    taken = taken + 8'd1;
                    if (taken >= frame_len) phase = srd_pkg::PH_CSUM;
                end
                srd_pkg::PH_CSUM: begin
                    if (b != sum) reject(srd_pkg::ST_BAD_SUM, b);
                    else phase = srd_pkg::PH_END1;
                end
                srd_pkg::PH_END1: begin
                    if (b != srd_pkg::BYTE_DELIM) reject(srd_pkg::ST_BAD_END, b);
                    else phase = srd_pkg::PH_END2;
                end
                srd_pkg::PH_END2: begin
                    if (b != srd_pkg::BYTE_END2) begin
                        reject(srd_pkg::ST_BAD_END, b);
                    end else begin
                        for (i = 0; i < frame_len && i < MAX_PAYLOAD; i++) begin
                            r.status  = srd_pkg::ST_DATA;
                            r.payload = store[i];
                            r.index   = i[srd_pkg::INDEX_W-1:0];
                            r.last    = (i + 1 == frame_len);
                            expected_q.push_back(r);
                        end
                        frames_good++;
                        phase = srd_pkg::PH_HUNT;
                    end
                end
                default: begin
                    phase = (b == srd_pkg::BYTE_DELIM) ? srd_pkg::PH_START2
                                                       : srd_pkg::PH_HUNT;
                end
            endcase
        endfunction

        function void check_result(t_reply got);
            t_reply want;
            if (expected_q.size() == 0) begin
                $display("[%0t] unexpected result (status/byte/index/last) %0d/%02h/%0d/%0d",
                         $time, got.status, got.payload, got.index, got.last);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.payload !== want.payload ||
                got.index !== want.index || got.last !== want.last) begin
                $display({"[%0t] result mismatch (status/byte/index/last): ",
                          "expected %0d/%02h/%0d/%0d, actual %0d/%02h/%0d/%0d"},
                         $time, want.status, want.payload, want.index, want.last,
                         got.status, got.payload, got.index, got.last);
                mismatches++;
            end else if (got.status == srd_pkg::ST_DATA) begin
                data_seen++;
            end else begin
                errors_seen[got.status]++;
            end
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [1:0]  paddr   = 2'd0;
    logic [31:0] pwdata  = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    logic        rx_valid   = 1'b0;
    logic [7:0]  rx_data    = 8'd0;
    logic        rsp_ready  = 1'b0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned items_sent = 0;
    bit          quiet = 1'b0;
    t_reply      seen_rsp;

    frame_scoreboard sb;

    srd_in_if  rx_if ();
    srd_out_if rsp_if ();

    assign rx_if.valid   = rx_valid;
    assign rx_if.rx_byte = rx_data;
    assign rsp_if.ready  = rsp_ready;

    serial_response_deframer #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one; none in a quiet phase.
    function automatic int unsigned gap_len();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            seen_rsp.status  = rsp_if.status;
            seen_rsp.payload = rsp_if.payload_byte;
            seen_rsp.index   = rsp_if.payload_index;
            seen_rsp.last    = rsp_if.last;
            sb.check_result(seen_rsp);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (rx_if.valid && rx_if.ready) ||
            (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void sum_fold(inout logic [7:0] sum, inout bit seen,
                                     input logic [7:0] b);
        if (b == srd_pkg::BYTE_DELIM) begin
            if (seen) return;
            seen = 1'b1;
        end
        sum = sum + b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_data  <= b;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        sb.note_byte(b);
        items_sent++;
    endtask

    // Builds a frame with a correct checksum, then spoils one byte of it
    // when bad_pos points inside the frame. Too long a length sends the
    // header alone.
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                              input int bad_pos);
        logic [7:0] frame [$];
        logic [7:0] sum;
        logic [7:0] d;
        bit         seen;
        frame = '{srd_pkg::BYTE_DELIM, srd_pkg::BYTE_START2, srd_pkg::BYTE_ZERO, cmd, len};
        sum  = srd_pkg::SUM_SEED;
        seen = 1'b0;
        sum_fold(sum, seen, srd_pkg::BYTE_ZERO);
        sum_fold(sum, seen, cmd);
        sum_fold(sum, seen, len);
        if (len <= MAX_PAYLOAD) begin
            for (int i = 0; i < len; i++) begin
                d = ($urandom_range(0, 5) == 0) ? srd_pkg::BYTE_DELIM : 8'($urandom);
                frame.push_back(d);
                sum_fold(sum, seen, d);
            end
            frame.push_back(sum);
            frame.push_back(srd_pkg::BYTE_DELIM);
            frame.push_back(srd_pkg::BYTE_END2);
        end
        if (bad_pos >= 0 && bad_pos < frame.size()) begin
            do d = $urandom_range(0, 1) ? srd_pkg::BYTE_DELIM : 8'($urandom);
            while (d == frame[bad_pos]);
            frame[bad_pos] = d;
        end
        foreach (frame[i]) send_byte(frame[i]);
    endtask

    // The register may only change once the receiver has gone quiet.
    task automatic settle();
        rx_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic apb_write_command(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(srd_pkg::REG_REPLY_COMMAND * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_command(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== {24'd0, value[7:0]}) begin
            $display("[%0t] register read mismatch: expected %08h, actual %08h",
                     $time, {24'd0, value[7:0]}, prdata);
            sb.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [7:0]  settings [N_SETTINGS];
        logic [7:0]  cmd;
        logic [7:0]  len;
        int unsigned goal;
        int unsigned r;
        int          bad_pos;

        sb = new();
        settings = '{8'hFF, 8'($urandom), srd_pkg::BYTE_DELIM, 8'h00, 8'($urandom),
                     srd_pkg::BYTE_START2};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset command value: noise, a repeated
        // delimiter, a bad zero byte, an empty frame, a length above MAX_PAYLOAD and
        // a one-byte frame with a spoilt end byte.
        send_byte(8'h55);
        send_byte(srd_pkg::BYTE_DELIM);
        send_byte(srd_pkg::BYTE_DELIM);
        send_byte(srd_pkg::BYTE_START2);
        send_byte(8'h01);
        send_frame(8'h00, 8'd0, -1);
        send_frame(8'h00, 8'hFF, -1);
        send_frame(8'h00, 8'd1, 8);

        for (int s = 0; s < N_SETTINGS; s++) begin
            settle();
            quiet = (s == 2);
            cmd = settings[s];
            apb_write_command({24'($urandom_range(0, 32'hFF_FFFF)), cmd});
            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal) begin
                if ($urandom_range(0, 9) < 3) begin
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
                end
                r = $urandom_range(0, 99);
                if (r < 70) len = 8'($urandom_range(0, 6));
                else if (r < 85) len = 8'($urandom_range(7, MAX_PAYLOAD));
                else if (r < 92) len = $urandom_range(0, 1) ? 8'(MAX_PAYLOAD) : 8'd1;
                else len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
                bad_pos = -1;
                if ($urandom_range(0, 3) == 0)
                    bad_pos = int'($urandom_range(0, (len <= MAX_PAYLOAD) ? len + 7 : 4));
                send_frame(cmd, len, bad_pos);
            end
        end

        settle();
        $display("Sent %0d bytes under %0d command values: %0d good frames, %0d data results.",
                 items_sent, N_SETTINGS + 1, sb.frames_good, sb.data_seen);
        $display("Errors seen: start %0d, command %0d, length %0d, checksum %0d, end %0d.",
                 sb.errors_seen[srd_pkg::ST_BAD_START], sb.errors_seen[srd_pkg::ST_BAD_CMD],
                 sb.errors_seen[srd_pkg::ST_TOO_LONG], sb.errors_seen[srd_pkg::ST_BAD_SUM],
                 sb.errors_seen[srd_pkg::ST_BAD_END]);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
